>>> sv/ftcg_pkg.sv
package ftcg_pkg;

  localparam int ROW_W     = 12;
  localparam int COL_W     = 12;
  localparam int TEXEL_W   = 12;
  localparam int ADDR_W    = 24;
  localparam int VEC_W     = 18;
  localparam int POS_W     = 24;
  localparam int SCR_W     = 13;
  localparam int FP_W      = 32;
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;
  // multiplier operand is at most 19 bits (twice a plane component, or direction minus plane)
  localparam int MUL_STEPS = 19;

  typedef enum logic [2:0] {
    REG_DIR_X   = 3'd0,
    REG_DIR_Y   = 3'd1,
    REG_PLANE_X = 3'd2,
    REG_PLANE_Y = 3'd3,
    REG_POS_X   = 3'd4,
    REG_POS_Y   = 3'd5,
    REG_WIDTH   = 3'd6,
    REG_HEIGHT  = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_RD,
    S_MUL_SX,
    S_DIV_SX,
    S_MUL_SY,
    S_DIV_SY,
    S_MUL_PX,
    S_MUL_PY,
    S_PIX0,
    S_PIX1,
    S_DONE
  } ftcg_state_t;

  typedef enum logic {
    MDU_MUL = 1'b0,
    MDU_DIV = 1'b1
  } mdu_op_t;

  typedef struct packed {
    logic    start;
    mdu_op_t op;
  } mdu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mdu_stat_t;

endpackage

>>> sv/ftcg_ifs.sv
interface ftcg_in_if;
  import ftcg_pkg::*;

  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;

  modport source (output valid, output row, output col, input ready);
  modport sink (input valid, input row, input col, output ready);
endinterface

interface ftcg_out_if;
  import ftcg_pkg::*;

  logic               valid;
  logic               ready;
  logic [TEXEL_W-1:0] texel_index;
  logic [ADDR_W-1:0]  floor_addr;
  logic [ADDR_W-1:0]  ceiling_addr;
  logic               row_error;

  modport source (output valid, output texel_index, output floor_addr,
                  output ceiling_addr, output row_error, input ready);
  modport sink (input valid, input texel_index, input floor_addr,
                input ceiling_addr, input row_error, output ready);
endinterface

>>> sv/ftcg_mdu.sv
module ftcg_mdu #(
  parameter int DW = 47
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ftcg_pkg::mdu_req_t  req,
  input  logic [DW-1:0]       opa,
  input  logic [DW-1:0]       opb,
  output ftcg_pkg::mdu_stat_t stat,
  output logic [DW-1:0]       res
);
  import ftcg_pkg::*;

  localparam int CW = $clog2(DW + 1);
  localparam logic [CW-1:0] DIV_LAST = CW'(DW - 1);
  localparam logic [CW-1:0] MUL_LAST = CW'(MUL_STEPS - 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  mdu_op_t       op_r, op_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] a_r, a_nxt;
  logic [DW-1:0] b_r, b_nxt;
  logic [DW-1:0] acc_r, acc_nxt;

  logic [DW:0]   trial;
  logic [DW+1:0] add_x, add_y, add_s;
  logic          ge;

  // one shared adder: accumulate for multiply, trial subtract for divide
  always_comb begin
    trial = {acc_r, a_r[DW-1]};
    unique case (op_r)
      MDU_DIV: begin
        add_x = {1'b0, trial};
        add_y = ~{2'b0, b_r};
      end
      MDU_MUL: begin
        add_x = {2'b0, acc_r};
        add_y = b_r[0] ? {2'b0, a_r} : '0;
      end
    endcase
    add_s = add_x + add_y + {{(DW+1){1'b0}}, (op_r == MDU_DIV)};
    ge    = ~add_s[DW+1];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (!busy_r) begin
      if (req.start) begin
        busy_nxt = 1'b1;
        op_nxt   = req.op;
        cnt_nxt  = (req.op == MDU_DIV) ? DIV_LAST : MUL_LAST;
        a_nxt    = opa;
        b_nxt    = opb;
        acc_nxt  = '0;
      end
    end else begin
      unique case (op_r)
        MDU_DIV: begin
          acc_nxt = ge ? add_s[DW-1:0] : trial[DW-1:0];
          a_nxt   = {a_r[DW-2:0], ge};
        end
        MDU_MUL: begin
          acc_nxt = add_s[DW-1:0];
          a_nxt   = {a_r[DW-2:0], 1'b0};
          b_nxt   = {1'b0, b_r[DW-1:1]};
        end
      endcase
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= MDU_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign res       = (op_r == MDU_DIV) ? a_r : acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> sv/floor_texture_coord_gen_top.sv
// Floor and ceiling texture coordinate generator for a raycaster. Pixels of the lower
// half of the screen enter on in_ch in raster order; each yields one beat on out_ch with
// the floor texel index, the floor and mirrored ceiling framebuffer addresses and a flag
// for rows at or above the screen middle. A pixel with a nonzero column, or a flagged
// row, goes from acceptance through S_PIX0 and S_PIX1 to S_DONE, where the result is
// loaded. A pixel in column zero first runs the row setup on one shared shift-add
// multiplier / restoring divider: three divides of FRAC_BITS+31 steps and four
// multiplies of 19 steps. in_ch is ready whenever the sequencer is idle, even while a
// result still waits on out_ch. The view registers sit on an APB port at byte address
// 4*index; the user must write them only while idle, as the block does not enforce it.
module floor_texture_coord_gen_top #(
  parameter int TEX_WIDTH  = 64,
  parameter int TEX_HEIGHT = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ftcg_in_if.sink                       in_ch,
  ftcg_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ftcg_pkg::APB_AW-1:0]   paddr,
  input  logic [ftcg_pkg::APB_DW-1:0]   pwdata,
  output logic [ftcg_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import ftcg_pkg::*;

  localparam int DW  = FRAC_BITS + 31;
  localparam int RDW = FRAC_BITS + 12;
  localparam int TWB = $clog2(TEX_WIDTH + 1);
  localparam int THB = $clog2(TEX_HEIGHT + 1);
  localparam int PXW = FRAC_BITS + TWB;
  localparam int PYW = FRAC_BITS + THB;
  localparam int TSW = (TWB + THB + 1 > TEXEL_W) ? (TWB + THB + 1) : TEXEL_W;

  // configuration
  logic [VEC_W-1:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  logic [POS_W-1:0] pos_x_r, pos_y_r;
  logic [SCR_W-1:0] scr_w_r, scr_h_r;
  logic             cfg_wr;
  cfg_idx_t         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = cfg_idx_t'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_x_r   <= '0;
      dir_y_r   <= 18'h30000;
      plane_x_r <= 18'd43254;
      plane_y_r <= '0;
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      scr_w_r   <= 13'd640;
      scr_h_r   <= 13'd480;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DIR_X:   dir_x_r   <= pwdata[VEC_W-1:0];
        REG_DIR_Y:   dir_y_r   <= pwdata[VEC_W-1:0];
        REG_PLANE_X: plane_x_r <= pwdata[VEC_W-1:0];
        REG_PLANE_Y: plane_y_r <= pwdata[VEC_W-1:0];
        REG_POS_X:   pos_x_r   <= pwdata[POS_W-1:0];
        REG_POS_Y:   pos_y_r   <= pwdata[POS_W-1:0];
        REG_WIDTH:   scr_w_r   <= pwdata[SCR_W-1:0];
        REG_HEIGHT:  scr_h_r   <= pwdata[SCR_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_DIR_X:   prdata = {{(APB_DW-VEC_W){dir_x_r[VEC_W-1]}}, dir_x_r};
      REG_DIR_Y:   prdata = {{(APB_DW-VEC_W){dir_y_r[VEC_W-1]}}, dir_y_r};
      REG_PLANE_X: prdata = {{(APB_DW-VEC_W){plane_x_r[VEC_W-1]}}, plane_x_r};
      REG_PLANE_Y: prdata = {{(APB_DW-VEC_W){plane_y_r[VEC_W-1]}}, plane_y_r};
      REG_POS_X:   prdata = {{(APB_DW-POS_W){1'b0}}, pos_x_r};
      REG_POS_Y:   prdata = {{(APB_DW-POS_W){1'b0}}, pos_y_r};
      REG_WIDTH:   prdata = {{(APB_DW-SCR_W){1'b0}}, scr_w_r};
      REG_HEIGHT:  prdata = {{(APB_DW-SCR_W){1'b0}}, scr_h_r};
    endcase
  end

  // sequencer and item registers
  ftcg_state_t      state_r, state_nxt;
  logic             started_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] ydist_r;
  logic             err_r;
  logic [RDW-1:0]   rd_r;
  logic [FP_W-1:0]  fp_x_r, fp_y_r, step_x_r, step_y_r;
  logic [TWB-1:0]   tx_r;
  logic [THB-1:0]   ty_r;
  logic [ADDR_W-1:0]  fa_r, ca_r;
  logic [TEXEL_W-1:0] tex_r;

  logic               out_valid_r;
  logic [TEXEL_W-1:0] out_tex_r;
  logic [ADDR_W-1:0]  out_fa_r, out_ca_r;
  logic               out_err_r;

  logic       in_acc;
  logic [13:0] ydist_in;
  logic       err_in;
  logic       out_load;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign ydist_in    = {2'b0, in_ch.row} - {2'b0, scr_h_r[SCR_W-1:1]};
  assign err_in      = ydist_in[13] || (ydist_in == '0);
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // shared multiply / divide unit
  mdu_req_t      mdu_req;
  mdu_stat_t     mdu_stat;
  logic [DW-1:0] mdu_a, mdu_b, mdu_res;

  ftcg_mdu #(.DW(DW)) u_mdu (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mdu_req),
    .opa  (mdu_a),
    .opb  (mdu_b),
    .stat (mdu_stat),
    .res  (mdu_res)
  );

  logic [18:0] two_px, two_py, mag_2px, mag_2py;
  logic [18:0] dpx, dpy, mag_dpx, mag_dpy;
  logic [31:0] q32, sh32;

  always_comb begin
    two_px  = {plane_x_r, 1'b0};
    two_py  = {plane_y_r, 1'b0};
    mag_2px = two_px[18] ? (~two_px + 19'd1) : two_px;
    mag_2py = two_py[18] ? (~two_py + 19'd1) : two_py;
    dpx     = {dir_x_r[VEC_W-1], dir_x_r} - {plane_x_r[VEC_W-1], plane_x_r};
    dpy     = {dir_y_r[VEC_W-1], dir_y_r} - {plane_y_r[VEC_W-1], plane_y_r};
    mag_dpx = dpx[18] ? (~dpx + 19'd1) : dpx;
    mag_dpy = dpy[18] ? (~dpy + 19'd1) : dpy;
    q32     = mdu_res[31:0];
    sh32    = {1'b0, mdu_res[DW-1:FRAC_BITS]};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_acc) state_nxt = (err_in || in_ch.col != '0) ? S_PIX0 : S_DIV_RD;
      S_DIV_RD: if (mdu_stat.done) state_nxt = S_MUL_SX;
      S_MUL_SX: if (mdu_stat.done) state_nxt = S_DIV_SX;
      S_DIV_SX: if (mdu_stat.done) state_nxt = S_MUL_SY;
      S_MUL_SY: if (mdu_stat.done) state_nxt = S_DIV_SY;
      S_DIV_SY: if (mdu_stat.done) state_nxt = S_MUL_PX;
      S_MUL_PX: if (mdu_stat.done) state_nxt = S_MUL_PY;
      S_MUL_PY: if (mdu_stat.done) state_nxt = S_PIX0;
      S_PIX0:   state_nxt = S_PIX1;
      S_PIX1:   state_nxt = S_DONE;
      S_DONE:   if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mdu_req.start = 1'b0;
    mdu_req.op    = MDU_MUL;
    mdu_a         = DW'(rd_r);
    mdu_b         = '0;
    unique case (state_r)
      S_DIV_RD: begin
        mdu_req.start = !started_r;
        mdu_req.op    = MDU_DIV;
        mdu_a         = DW'(scr_h_r) << (FRAC_BITS - 1);
        mdu_b         = DW'(ydist_r);
      end
      S_MUL_SX: begin
        mdu_req.start = !started_r;
        mdu_b         = DW'(mag_2px);
      end
      S_MUL_SY: begin
        mdu_req.start = !started_r;
        mdu_b         = DW'(mag_2py);
      end
      S_DIV_SX, S_DIV_SY: begin
        mdu_req.start = !started_r;
        mdu_req.op    = MDU_DIV;
        mdu_a         = mdu_res;
        mdu_b         = DW'(scr_w_r) << FRAC_BITS;
      end
      S_MUL_PX: begin
        mdu_req.start = !started_r;
        mdu_b         = DW'(mag_dpx);
      end
      S_MUL_PY: begin
        mdu_req.start = !started_r;
        mdu_b         = DW'(mag_dpy);
      end
      default: begin
        mdu_req.start = 1'b0;
      end
    endcase
  end

  // address multiplier and texel math
  logic [13:0]       cf14;
  logic [ADDR_W-1:0] amul_a, amul_p;
  logic [PXW-1:0]    prod_x;
  logic [PYW-1:0]    prod_y;
  logic [TSW-1:0]    tsum;

  always_comb begin
    cf14   = {1'b0, scr_h_r} - {2'b0, row_r} - 14'd1;
    amul_a = (state_r == S_PIX0) ? ADDR_W'(row_r)
                                 : {{(ADDR_W-14){cf14[13]}}, cf14};
    amul_p = amul_a * ADDR_W'(scr_w_r);
    prod_x = PXW'(fp_x_r[FRAC_BITS-1:0]) * PXW'(TEX_WIDTH);
    prod_y = PYW'(fp_y_r[FRAC_BITS-1:0]) * PYW'(TEX_HEIGHT);
    tsum   = TSW'(ty_r) * TSW'(TEX_WIDTH) + TSW'(tx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
      fp_x_r      <= '0;
      fp_y_r      <= '0;
      step_x_r    <= '0;
      step_y_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (mdu_req.start) begin
        started_r <= 1'b1;
      end else if (mdu_stat.done) begin
        started_r <= 1'b0;
      end
      out_valid_r <= out_load || (out_valid_r && !out_ch.ready);
      if (mdu_stat.done) begin
        unique case (state_r)
          S_DIV_SX: step_x_r <= (scr_w_r == '0) ? '0
                                : (plane_x_r[VEC_W-1] ? (~q32 + 32'd1) : q32);
          S_DIV_SY: step_y_r <= (scr_w_r == '0) ? '0
                                : (plane_y_r[VEC_W-1] ? (~q32 + 32'd1) : q32);
          S_MUL_PX: fp_x_r <= FP_W'(pos_x_r) + (dpx[18] ? (~sh32 + 32'd1) : sh32);
          S_MUL_PY: fp_y_r <= FP_W'(pos_y_r) + (dpy[18] ? (~sh32 + 32'd1) : sh32);
          default: begin
          end
        endcase
      end
      if (state_r == S_PIX0 && !err_r) begin
        fp_x_r <= fp_x_r + step_x_r;
        fp_y_r <= fp_y_r + step_y_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      row_r   <= in_ch.row;
      col_r   <= in_ch.col;
      ydist_r <= ydist_in[ROW_W-1:0];
      err_r   <= err_in;
    end
    if (state_r == S_DIV_RD && mdu_stat.done) begin
      rd_r <= mdu_res[RDW-1:0];
    end
    if (state_r == S_PIX0) begin
      tx_r <= prod_x[PXW-1:FRAC_BITS] & TWB'(TEX_WIDTH - 1);
      ty_r <= prod_y[PYW-1:FRAC_BITS] & THB'(TEX_HEIGHT - 1);
      fa_r <= amul_p + ADDR_W'(col_r);
    end
    if (state_r == S_PIX1) begin
      ca_r  <= amul_p + ADDR_W'(col_r);
      tex_r <= err_r ? '0 : tsum[TEXEL_W-1:0];
    end
    if (out_load) begin
      out_tex_r <= tex_r;
      out_fa_r  <= fa_r;
      out_ca_r  <= ca_r;
      out_err_r <= err_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.texel_index  = out_tex_r;
  assign out_ch.floor_addr   = out_fa_r;
  assign out_ch.ceiling_addr = out_ca_r;
  assign out_ch.row_error    = out_err_r;

endmodule

>>> verif/floor_texture_coord_gen_checker.sv
`timescale 1ns / 1ps

module floor_texture_coord_gen_checker #(
  parameter int TEX_WIDTH  = 64,
  parameter int TEX_HEIGHT = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ftcg_in_if                          in_ch,
  ftcg_out_if                         out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [ftcg_pkg::APB_AW-1:0] paddr,
  input  logic [ftcg_pkg::APB_DW-1:0] pwdata,
  output int                          pending,
  output int                          mismatches
);
  import ftcg_pkg::*;

  typedef struct {
    logic [TEXEL_W-1:0] texel;
    logic [ADDR_W-1:0]  floor_addr;
    logic [ADDR_W-1:0]  ceiling_addr;
    logic               row_error;
  } pixel_result_t;

  pixel_result_t expected_pixels[$];

  logic signed [VEC_W-1:0] view_dir_x, view_dir_y, cam_plane_x, cam_plane_y;
  logic [POS_W-1:0]        eye_x, eye_y;
  logic [SCR_W-1:0]        scr_w, scr_h;
  logic [FP_W-1:0]         walk_x, walk_y, stride_x, stride_y;

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
  endtask

  function automatic pixel_result_t predict_pixel(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    longint        y, rowdist, den, scale;
    logic [63:0]   tex_u, tex_v;
    pixel_result_t res;
    y = longint'(r) - longint'(scr_h >> 1);
    res.texel = '0;
    res.row_error = (y <= 0);
    if (!res.row_error) begin
      // row setup
      if (c == '0) begin
        scale = longint'(1) <<< FRAC_BITS;
        rowdist = (longint'(scr_h) <<< (FRAC_BITS - 1)) / y;
        if (scr_w != '0) begin
          den = longint'(scr_w) <<< FRAC_BITS;
          stride_x = FP_W'((rowdist * 2 * longint'(cam_plane_x)) / den);
          stride_y = FP_W'((rowdist * 2 * longint'(cam_plane_y)) / den);
        end else begin
          stride_x = '0;
          stride_y = '0;
        end
        walk_x = FP_W'(longint'(eye_x) +
                       (rowdist * (longint'(view_dir_x) - longint'(cam_plane_x))) / scale);
        walk_y = FP_W'(longint'(eye_y) +
                       (rowdist * (longint'(view_dir_y) - longint'(cam_plane_y))) / scale);
      end
      tex_u = ((64'(walk_x[FRAC_BITS-1:0]) * TEX_WIDTH) >> FRAC_BITS) & (TEX_WIDTH - 1);
      tex_v = ((64'(walk_y[FRAC_BITS-1:0]) * TEX_HEIGHT) >> FRAC_BITS) & (TEX_HEIGHT - 1);
      res.texel = TEXEL_W'(TEX_WIDTH * tex_v + tex_u);
      walk_x = walk_x + stride_x;
      walk_y = walk_y + stride_y;
    end
    res.floor_addr = ADDR_W'(64'(r) * 64'(scr_w) + 64'(c));
    res.ceiling_addr = ADDR_W'((64'(scr_h) - 64'(r) - 64'd1) * 64'(scr_w) + 64'(c));
    return res;
  endfunction

  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst_n) begin
      view_dir_x  = 0;
      view_dir_y  = -65536;
      cam_plane_x = 43254;
      cam_plane_y = 0;
      eye_x       = '0;
      eye_y       = '0;
      scr_w       = 640;
      scr_h       = 480;
      walk_x      = '0;
      walk_y      = '0;
      stride_x    = '0;
      stride_y    = '0;
      expected_pixels.delete();
      pending     = 0;
      mismatches  = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("out_ch beat with no pixel pending (floor_addr %0h)",
                                    out_ch.floor_addr));
        end else begin
          want = expected_pixels.pop_front();
          check_field("texel_index", 32'(out_ch.texel_index), 32'(want.texel));
          check_field("floor_addr", 32'(out_ch.floor_addr), 32'(want.floor_addr));
          check_field("ceiling_addr", 32'(out_ch.ceiling_addr), 32'(want.ceiling_addr));
          check_field("row_error", 32'(out_ch.row_error), 32'(want.row_error));
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_pixels.push_back(predict_pixel(in_ch.row, in_ch.col));
      if (psel && penable && pwrite && pready) begin
        case (cfg_idx_t'(paddr[APB_AW-1:2]))
          REG_DIR_X:   view_dir_x  = pwdata[VEC_W-1:0];
          REG_DIR_Y:   view_dir_y  = pwdata[VEC_W-1:0];
          REG_PLANE_X: cam_plane_x = pwdata[VEC_W-1:0];
          REG_PLANE_Y: cam_plane_y = pwdata[VEC_W-1:0];
          REG_POS_X:   eye_x       = pwdata[POS_W-1:0];
          REG_POS_Y:   eye_y       = pwdata[POS_W-1:0];
          REG_WIDTH:   scr_w       = pwdata[SCR_W-1:0];
          REG_HEIGHT:  scr_h       = pwdata[SCR_W-1:0];
          default: ;
        endcase
      end
      pending = expected_pixels.size();
    end
  end

endmodule

>>> verif/floor_texture_coord_gen_top_tb.sv
`timescale 1ns / 1ps

module floor_texture_coord_gen_top_tb;
  import ftcg_pkg::*;

  localparam int TEX_WIDTH    = 64;
  localparam int TEX_HEIGHT   = 64;
  localparam int FRAC_BITS    = 16;
  localparam int TOTAL_PIXELS = 1325;
  localparam int QUIET_TAIL   = 150;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  logic in_fire;
  logic apb_fire;
  bit   quiet;
  int   pending;
  int   mismatches;
  int   sent;
  int   cur_w;
  int   cur_h;

  ftcg_in_if  in_ch ();
  ftcg_out_if out_ch ();

  floor_texture_coord_gen_top #(
    .TEX_WIDTH  (TEX_WIDTH),
    .TEX_HEIGHT (TEX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  floor_texture_coord_gen_checker #(
    .TEX_WIDTH  (TEX_WIDTH),
    .TEX_HEIGHT (TEX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pending    (pending),
    .mismatches (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    in_fire  <= in_ch.valid && in_ch.ready;
    apb_fire <= psel && penable && pwrite && pready;
  end

  // result side back-pressure
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 6) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_ch.ready = 1'b1;
    end
  end

  task automatic push_pixel(input int r, input int c);
    in_ch.valid = 1'b1;
    in_ch.row   = ROW_W'(r);
    in_ch.col   = COL_W'(c);
    do @(negedge clk); while (!in_fire);
    sent++;
    if (sent >= TOTAL_PIXELS - QUIET_TAIL)
      quiet = 1'b1;
    if (!quiet && $urandom_range(0, 11) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(negedge clk); while (!apb_fire);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (idx == REG_WIDTH)
      cur_w = value;
    if (idx == REG_HEIGHT)
      cur_h = value;
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic int rand_vec();
    case ($urandom_range(0, 5))
      0:       return -131072;
      1:       return 131071;
      2:       return 0;
      default: return int'($urandom_range(0, 262143)) - 131072;
    endcase
  endfunction

  function automatic int rand_pos();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 24'hFFFFFF;
      default: return int'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  initial begin
    int  nitems;
    int  k;
    int  ncols;
    int  row_cur;
    int  w;
    int  h;
    bit  first;

    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.row   = '0;
    in_ch.col   = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    quiet       = 1'b0;
    sent        = 0;
    cur_w       = 640;
    cur_h       = 480;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset view: nearest row, middle row, rows above it, rows past the bottom, last row
    push_pixel(241, 0);
    push_pixel(241, 1);
    push_pixel(241, 4095);
    push_pixel(240, 0);
    push_pixel(0, 0);
    push_pixel(100, 5);
    push_pixel(4095, 0);
    push_pixel(4095, 4095);
    push_pixel(479, 0);
    push_pixel(479, 639);

    wait_drained();
    write_reg(REG_DIR_X, -131072);
    write_reg(REG_DIR_Y, 131071);
    write_reg(REG_PLANE_X, 131071);
    write_reg(REG_PLANE_Y, -131072);
    write_reg(REG_POS_X, 24'hFFFFFF);
    write_reg(REG_POS_Y, 0);
    write_reg(REG_WIDTH, 4096);
    write_reg(REG_HEIGHT, 4096);
    push_pixel(2049, 0);
    push_pixel(2049, 1);
    push_pixel(2049, 2);
    push_pixel(2048, 0);
    push_pixel(4095, 0);

    // zero width, smallest height
    wait_drained();
    write_reg(REG_DIR_X, 131071);
    write_reg(REG_DIR_Y, -131072);
    write_reg(REG_PLANE_X, -131072);
    write_reg(REG_PLANE_Y, 131071);
    write_reg(REG_POS_X, 0);
    write_reg(REG_POS_Y, 24'hFFFFFF);
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 2);
    push_pixel(2, 0);
    push_pixel(2, 1);
    push_pixel(1, 0);
    push_pixel(4095, 4095);

    // odd height, single column
    wait_drained();
    write_reg(REG_WIDTH, 1);
    write_reg(REG_HEIGHT, 481);
    push_pixel(241, 0);
    push_pixel(241, 1);
    push_pixel(240, 3);
    push_pixel(480, 0);

    first = 1'b1;
    while (sent < TOTAL_PIXELS) begin
      wait_drained();
      if (first || $urandom_range(0, 1)) write_reg(REG_DIR_X, rand_vec());
      if (first || $urandom_range(0, 1)) write_reg(REG_DIR_Y, rand_vec());
      if (first || $urandom_range(0, 1)) write_reg(REG_PLANE_X, rand_vec());
      if (first || $urandom_range(0, 1)) write_reg(REG_PLANE_Y, rand_vec());
      if (first || $urandom_range(0, 1)) write_reg(REG_POS_X, rand_pos());
      if (first || $urandom_range(0, 1)) write_reg(REG_POS_Y, rand_pos());
      if (first || $urandom_range(0, 1)) begin
        case ($urandom_range(0, 9))
          0:       w = 0;
          1:       w = 4096;
          2:       w = 1;
          3:       w = $urandom_range(1, 4096);
          default: w = $urandom_range(2, 48);
        endcase
        write_reg(REG_WIDTH, w);
      end
      if (first || $urandom_range(0, 1)) begin
        case ($urandom_range(0, 9))
          0:       h = 2;
          1:       h = 4096;
          2:       h = $urandom_range(2, 4096);
          3:       h = $urandom_range(1, 40) * 2 + 1;
          default: h = $urandom_range(4, 80);
        endcase
        write_reg(REG_HEIGHT, h);
      end
      first   = 1'b0;
      nitems  = $urandom_range(40, 120);
      row_cur = cur_h / 2 + 1;
      k       = 0;
      while (k < nitems) begin
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0:       push_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
            1:       push_pixel($urandom_range(0, cur_h / 2), $urandom_range(0, 4095));
            2:       push_pixel(row_cur, $urandom_range(1, 4095));
            default: push_pixel($urandom_range(cur_h < 4095 ? cur_h : 4095, 4095),
                                $urandom_range(0, 4095));
          endcase
          k++;
        end else begin
          ncols = $urandom_range(1, 24);
          if (cur_w == 0)
            ncols = $urandom_range(1, 4);
          else if (ncols > cur_w)
            ncols = cur_w;
          for (int c = 0; c < ncols; c++) begin
            push_pixel(row_cur, c);
            k++;
          end
          row_cur++;
          if (row_cur >= cur_h || row_cur > 4095)
            row_cur = cur_h / 2 + 1;
        end
      end
    end

    in_ch.valid = 1'b0;
    for (int i = 0; i < 100000 && pending != 0; i++) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (pending != 0)
        $display("%0d pixel results never arrived", pending);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
sv/ftcg_pkg.sv
sv/ftcg_ifs.sv
sv/ftcg_mdu.sv
sv/floor_texture_coord_gen_top.sv
verif/floor_texture_coord_gen_checker.sv
verif/floor_texture_coord_gen_top_tb.sv
